// ===== hdl/rht_pkg.sv =====
// Shared types, constants and codes for the reference-counted host table.
package rht_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int COUNT_BITS    = 8;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [31:0] NET_MASK_RESET = 32'hFF00_0000;

   localparam int FLAG_UP_BIT   = 0;
   localparam int FLAG_TEMP_BIT = 1;

   localparam logic [1:0] CMD_FIND  = 2'd0;
   localparam logic [1:0] CMD_MAKE  = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;
   localparam logic [1:0] CMD_RESET = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOTFOUND  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_SATURATED = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_FREE,
      ACT_NET_CLEAR,
      ACT_MAKE_HIT,
      ACT_MAKE_NEW
   } act_type;

   typedef struct packed {
      logic [31:0]           addr;
      logic [COUNT_BITS-1:0] count;
      logic [1:0]            flags;
   } entry_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] host_addr;
      logic        is_temp;
      logic [4:0]  entry_index;
      logic [31:0] net_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] result_index;
      logic [7:0] ref_count;
      logic [1:0] entry_flags;
   } rsp_type;

   typedef struct packed {
      act_type     act;
      logic        fire;
      logic [31:0] addr;
      logic        is_temp;
      logic [31:0] net;
      logic [31:0] mask;
   } edit_ctl_type;

   typedef struct packed {
      logic live_match;
      logic empty;
   } probe_type;

endpackage

// ===== hdl/rht_cell.sv =====
// One table cell: holds a single entry and takes its neighbor's entry on a shift.
module rht_cell import rht_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type d,
   output entry_type q
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift ? d : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q = entry_ff;

endmodule

// ===== hdl/rht_edit.sv =====
// Edit unit at the head of the ring: probes the passing entry and applies one command.
module rht_edit import rht_pkg::*; (
   input  entry_type    entry_i,
   input  edit_ctl_type ctl,
   output entry_type    entry_o,
   output logic [1:0]   status,
   output probe_type    probe
);

   always_comb begin
      entry_o          = entry_i;
      status           = ST_OK;
      probe.live_match = (entry_i.count != '0) && (entry_i.addr == ctl.addr);
      probe.empty      = (entry_i.count == '0);
      if (ctl.fire) begin
         unique case (ctl.act)
            ACT_FREE: begin
               if (entry_i.count == '0) begin
                  status = ST_UNDERFLOW;
               end else if (entry_i.count == COUNT_BITS'(1)) begin
                  entry_o = '0;
               end else begin
                  entry_o.count = entry_i.count - COUNT_BITS'(1);
               end
            end
            ACT_NET_CLEAR: begin
               if ((entry_i.addr & ctl.mask) == ctl.net) begin
                  entry_o.flags = '0;
               end
            end
            ACT_MAKE_HIT: begin
               if (entry_i.flags[FLAG_TEMP_BIT]) begin
                  entry_o.flags[FLAG_TEMP_BIT] = 1'b0;
               end else if (entry_i.count == CNT_MAX) begin
                  status = ST_SATURATED;
               end else begin
                  entry_o.count = entry_i.count + COUNT_BITS'(1);
               end
            end
            ACT_MAKE_NEW: begin
               entry_o.addr                 = ctl.addr;
               entry_o.count                = COUNT_BITS'(1);
               entry_o.flags                = '0;
               entry_o.flags[FLAG_UP_BIT]   = 1'b1;
               entry_o.flags[FLAG_TEMP_BIT] = ctl.is_temp;
            end
            default: begin
               entry_o = entry_i;
            end
         endcase
      end
   end

endmodule

// ===== hdl/refcounted_host_table_top.sv =====
// Top level of the reference-counted host table: cell ring, edit unit and sequencer.
//
// A command beat is taken when start is high and busy is low; busy stays high
// until the result has been shown. The result appears on rsp_data for exactly
// one cycle with rsp_valid high and cannot be held off by the receiver.
// The configuration channel (csr_valid/csr_ready/csr_wdata) writes the network
// mask used by the reset-network command; it is always ready and is meant to
// be written while the block is idle.
//
// The entries live in a ring of TABLE_ENTRIES cells that rotates by one cell
// per cycle through the edit unit while a pass runs, so one full pass visits
// every entry once. Find, free and reset-network take one pass; the result
// strobe is then shown from the done state, and busy drops when it ends. Make
// adds an update pass, unless the scan finds neither a matching entry nor a
// free cell, in which case it takes one pass.
// Synchronous reset empties every entry, sets the mask to 0xFF000000 and
// returns to idle.
module refcounted_host_table_top import rht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [31:0]      mask_ff, mask_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] target_ff, target_in;
   logic             idx_ok_ff, idx_ok_in;
   act_type          act_ff, act_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   entry_type        res_entry_ff, res_entry_in;

   entry_type        cell_q [TABLE_ENTRIES];
   entry_type        edit_out;
   logic [1:0]       edit_status;
   probe_type        probe;
   edit_ctl_type     ctl;
   logic             shift;
   logic             new_hit, new_free, hit_any, free_any;
   logic [IDX_W-1:0] hit_idx_any, free_idx_any;

   // Ring of cells: each takes its upper neighbor, the last takes the edited head.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_ring
      entry_type d;
      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign d = edit_out;
      end else begin : g_mid
         assign d = cell_q[i+1];
      end
      rht_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     (d),
         .q     (cell_q[i])
      );
   end

   always_comb begin
      ctl.addr    = req_ff.host_addr;
      ctl.is_temp = req_ff.is_temp;
      ctl.net     = req_ff.net_value;
      ctl.mask    = mask_ff;
      ctl.act     = ACT_NONE;
      ctl.fire    = 1'b0;
      if (state_ff == S_SCAN) begin
         if (req_ff.cmd == CMD_FREE) begin
            ctl.act  = ACT_FREE;
            ctl.fire = idx_ok_ff && (k_ff == target_ff);
         end else if (req_ff.cmd == CMD_RESET) begin
            ctl.act  = ACT_NET_CLEAR;
            ctl.fire = 1'b1;
         end
      end else if (state_ff == S_APPLY) begin
         ctl.act  = act_ff;
         ctl.fire = (k_ff == target_ff);
      end
   end

   rht_edit u_edit (
      .entry_i (cell_q[0]),
      .ctl     (ctl),
      .entry_o (edit_out),
      .status  (edit_status),
      .probe   (probe)
   );

   assign shift = (state_ff == S_SCAN) || (state_ff == S_APPLY);

   // Lookup bookkeeping, including the entry at the head in this cycle.
   always_comb begin
      new_hit = probe.live_match && !hit_ff &&
                ((req_ff.cmd == CMD_FIND) ||
                 ((req_ff.cmd == CMD_MAKE) && !req_ff.is_temp));
      new_free     = probe.empty && !free_ff;
      hit_any      = hit_ff || new_hit;
      hit_idx_any  = hit_ff ? hit_idx_ff : k_ff;
      free_any     = free_ff || new_free;
      free_idx_any = free_ff ? free_idx_ff : k_ff;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      mask_in       = mask_ff;
      k_in          = k_ff;
      target_in     = target_ff;
      idx_ok_in     = idx_ok_ff;
      act_in        = act_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_entry_in  = res_entry_ff;
      busy          = 1'b1;
      rsp_valid     = 1'b0;

      if (csr_valid) begin
         mask_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               req_in    = req_data;
               k_in      = '0;
               target_in = IDX_W'(req_data.entry_index);
               idx_ok_in = int'(req_data.entry_index) < TABLE_ENTRIES;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            k_in = k_ff + IDX_W'(1);
            if (new_hit) begin
               hit_in       = 1'b1;
               hit_idx_in   = k_ff;
               res_entry_in = cell_q[0];
            end
            if (new_free) begin
               free_in     = 1'b1;
               free_idx_in = k_ff;
            end
            if (ctl.fire && (req_ff.cmd == CMD_FREE)) begin
               res_entry_in  = edit_out;
               res_status_in = edit_status;
               res_idx_in    = k_ff;
            end
            if (k_ff == LAST_IDX) begin
               k_in     = '0;
               state_in = S_DONE;
               unique case (req_ff.cmd)
                  CMD_FIND: begin
                     res_status_in = hit_any ? ST_OK : ST_NOTFOUND;
                     res_idx_in    = hit_any ? hit_idx_any : '0;
                     if (!hit_any) begin
                        res_entry_in = '0;
                     end
                  end
                  CMD_MAKE: begin
                     if (hit_any) begin
                        act_in    = ACT_MAKE_HIT;
                        target_in = hit_idx_any;
                        state_in  = S_APPLY;
                     end else if (free_any) begin
                        act_in    = ACT_MAKE_NEW;
                        target_in = free_idx_any;
                        state_in  = S_APPLY;
                     end else begin
                        res_status_in = ST_NOTFOUND;
                        res_idx_in    = '0;
                        res_entry_in  = '0;
                     end
                  end
                  CMD_FREE: begin
                     if (!idx_ok_ff) begin
                        res_status_in = ST_NOTFOUND;
                        res_idx_in    = '0;
                        res_entry_in  = '0;
                     end
                  end
                  CMD_RESET: begin
                     res_status_in = ST_OK;
                     res_idx_in    = '0;
                     res_entry_in  = '0;
                  end
                  default: begin
                     res_status_in = ST_NOTFOUND;
                  end
               endcase
            end
         end
         S_APPLY: begin
            k_in = k_ff + IDX_W'(1);
            if (ctl.fire) begin
               res_entry_in  = edit_out;
               res_status_in = edit_status;
               res_idx_in    = k_ff;
            end
            if (k_ff == LAST_IDX) begin
               k_in     = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mask_ff  <= NET_MASK_RESET;
         k_ff     <= '0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
         k_ff     <= k_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      target_ff     <= target_in;
      idx_ok_ff     <= idx_ok_in;
      act_ff        <= act_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_entry_ff  <= res_entry_in;
   end

   assign csr_ready             = 1'b1;
   assign rsp_data.status       = res_status_ff;
   assign rsp_data.result_index = 5'(res_idx_ff);
   assign rsp_data.ref_count    = 8'(res_entry_ff.count);
   assign rsp_data.entry_flags  = res_entry_ff.flags;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted command did not raise busy");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result beat lasted more than one cycle");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_NOTFOUND)) |->
      (rsp_data.result_index == '0 && rsp_data.ref_count == '0 &&
       rsp_data.entry_flags == '0))
      else $error("not-found result carries entry fields");

   a_pass_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_APPLY) && (k_ff == LAST_IDX)) |=> rsp_valid)
      else $error("update pass did not end in a result");

endmodule
